[src/mit_pkg.sv]
`timescale 1ns / 1ps

package mit_pkg;

  // Status of one step of the shared add-and-reduce unit.
  typedef struct packed {
    logic ge;    // the raw sum reached the modulus or divisor
    logic zero;  // the reduced sum is zero
  } mit_flags_t;

endpackage

[src/mit_if.sv]
`timescale 1ns / 1ps

// Input channel: one value to invert per transaction.
interface mit_in_if #(
  parameter int unsigned W = 31
);
  logic         valid;
  logic         ready;
  logic [W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output channel: one result per transaction.
interface mit_out_if #(
  parameter int unsigned W = 31
);
  logic         valid;
  logic         ready;
  logic [W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[src/mit_alu.sv]
`timescale 1ns / 1ps

// Shared arithmetic unit: y = (a + b + cin) reduced once by d.
// Serves one restoring-division step (a = b = remainder, cin = next dividend bit)
// and the doubling and adding steps of a modular multiplication.
module mit_alu
  import mit_pkg::*;
#(
  parameter int unsigned MB = 31
) (
  input  logic [MB-1:0] a_i,
  input  logic [MB-1:0] b_i,
  input  logic          cin_i,
  input  logic [MB-1:0] d_i,
  output logic [MB-1:0] y_o,
  output mit_flags_t    flags_o
);

  logic [MB:0] sum;
  logic [MB:0] diff;
  logic        ge;

  // Sum of the operands, one bit wider than the operands.
  assign sum  = {1'b0, a_i} + {1'b0, b_i} + {{MB{1'b0}}, cin_i};
  assign ge   = (sum >= {1'b0, d_i});
  assign diff = sum - {1'b0, d_i};

  // A single conditional subtraction suffices since the sum stays below 2*d.
  assign y_o          = ge ? diff[MB-1:0] : sum[MB-1:0];
  assign flags_o.ge   = ge;
  assign flags_o.zero = (y_o == '0);

endmodule

[src/modular_inverse_by_totient.sv]
`timescale 1ns / 1ps

// Channel   Direction  Transaction carries
// in_ch_i   sink       value  [MOD_BITS-1:0]  number to invert
// out_ch_o  source     result [MOD_BITS-1:0]  value^(phi(m)-1) mod m
// APB       slave      modulus register at address 0
//
// Every step runs on one add-and-reduce unit: the input reduction, then the divisions
// by each trial divisor up to sqrt(m), then the power (a squaring and at most one
// multiplication per exponent bit).
// in_ch_i is ready only when idle. A finished result waits in the output register; a
// stalled sink holds the next item in its last state. Reset sets the modulus to 2.
module modular_inverse_by_totient
  import mit_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic clk_i,
  input  logic rst_ni,

  mit_in_if.sink    in_ch_i,
  mit_out_if.source out_ch_o,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [((MOD_BITS > 32) ? 4 : 3)-1:0] paddr,
  input  logic [((MOD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((MOD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                                 pready
);

  localparam int unsigned MB = MOD_BITS;
  localparam int unsigned DW = (MB > 32) ? 64 : 32;
  localparam int unsigned AW = (MB > 32) ? 4 : 3;
  localparam int unsigned CW = $clog2(MB);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_TCHK  = 4'd2;
  localparam logic [3:0] S_TDIV  = 4'd3;
  localparam logic [3:0] S_TPHI  = 4'd4;
  localparam logic [3:0] S_TLAST = 4'd5;
  localparam logic [3:0] S_EXP   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [CW-1:0] CNT_TOP = CW'(MB - 1);

  logic [3:0]    state_q, state_d;
  logic [MB-1:0] mod_q;
  logic [MB-1:0] m_eff;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [MB-1:0] dq_q, dq_d;     // dividend shifting into quotient, or multiplier
  logic [MB-1:0] rem_q, rem_d;   // remainder, or product accumulator
  logic [MB-1:0] dvs_q, dvs_d;
  logic [MB-1:0] rest_q, rest_d;
  logic [MB-1:0] phi_q, phi_d;
  logic [MB-1:0] d_q, d_d;
  logic [MB:0]   dsq_q, dsq_d;
  logic          found_q, found_d;
  logic [MB-1:0] base_q, base_d;
  logic [MB-1:0] acc_q, acc_d;
  logic [MB-1:0] exp_q, exp_d;
  logic [CW-1:0] ecnt_q, ecnt_d;
  logic [MB-1:0] mx_q, mx_d;
  logic          mphase_q, mphase_d;
  logic          mop_q, mop_d;
  logic [MB-1:0] res_q, res_d;
  logic          ov_q, ov_d;

  logic [MB-1:0] alu_b, alu_d, alu_y;
  logic          alu_cin;
  mit_flags_t    alu_flags;
  logic [MB-1:0] quot;
  logic          cfg_wr;

  // Configuration port: one register, written in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[AW-1];
  assign prdata = paddr[AW-1] ? '0 : DW'(mod_q);
  assign m_eff  = (mod_q < MB'(2)) ? MB'(2) : mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MB'(2);
    end else if (cfg_wr) begin
      mod_q <= pwdata[MB-1:0];
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_b   = rem_q;
    alu_cin = dq_q[MB-1];
    alu_d   = dvs_q;
    if (state_q == S_MUL) begin
      alu_cin = 1'b0;
      alu_d   = m_eff;
      if (mphase_q) begin
        alu_b = dq_q[MB-1] ? mx_q : '0;
      end
    end
  end

  mit_alu #(
    .MB(MB)
  ) u_alu (
    .a_i    (rem_q),
    .b_i    (alu_b),
    .cin_i  (alu_cin),
    .d_i    (alu_d),
    .y_o    (alu_y),
    .flags_o(alu_flags)
  );

  assign quot = {dq_q[MB-2:0], alu_flags.ge};

  assign in_ch_i.ready  = (state_q == S_IDLE);
  assign out_ch_o.valid = ov_q;
  assign out_ch_o.result = res_q;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    rest_d   = rest_q;
    phi_d    = phi_q;
    d_d      = d_q;
    dsq_d    = dsq_q;
    found_d  = found_q;
    base_d   = base_q;
    acc_d    = acc_q;
    exp_d    = exp_q;
    ecnt_d   = ecnt_q;
    mx_d     = mx_q;
    mphase_d = mphase_q;
    mop_d    = mop_q;
    res_d    = res_q;
    ov_d     = ov_q && !out_ch_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_ch_i.valid) begin
          dq_d    = in_ch_i.value;
          rem_d   = '0;
          dvs_d   = m_eff;
          cnt_d   = CNT_TOP;
          state_d = S_RED;
        end
      end

      // Input value modulo m.
      S_RED: begin
        dq_d  = quot;
        rem_d = alu_y;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          base_d  = alu_y;
          rest_d  = m_eff;
          phi_d   = m_eff;
          d_d     = MB'(2);
          dsq_d   = (MB + 1)'(4);
          found_d = 1'b0;
          state_d = S_TCHK;
        end
      end

      // Trial divisor bound: continue while d*d <= rest.
      S_TCHK: begin
        rem_d = '0;
        cnt_d = CNT_TOP;
        if (dsq_q <= {1'b0, rest_q}) begin
          dq_d    = rest_q;
          dvs_d   = d_q;
          state_d = S_TDIV;
        end else if (rest_q > MB'(1)) begin
          dq_d    = phi_q;
          dvs_d   = rest_q;
          state_d = S_TLAST;
        end else begin
          state_d = S_EXP;
        end
      end

      // Strip all factors d from rest.
      S_TDIV: begin
        dq_d  = quot;
        rem_d = alu_y;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d = '0;
          cnt_d = CNT_TOP;
          if (alu_flags.zero) begin
            rest_d  = quot;
            found_d = 1'b1;
          end else if (found_q) begin
            dq_d    = phi_q;
            state_d = S_TPHI;
          end else begin
            d_d     = d_q + 1'b1;
            dsq_d   = dsq_q + {d_q, 1'b1};
            state_d = S_TCHK;
          end
        end
      end

      // phi = (phi / d) * (d - 1) = phi - remainder - quotient.
      S_TPHI: begin
        dq_d  = quot;
        rem_d = alu_y;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phi_d   = phi_q - alu_y - quot;
          found_d = 1'b0;
          d_d     = d_q + 1'b1;
          dsq_d   = dsq_q + {d_q, 1'b1};
          state_d = S_TCHK;
        end
      end

      // Last prime factor, left in rest once d*d exceeds it.
      S_TLAST: begin
        dq_d  = quot;
        rem_d = alu_y;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phi_d   = phi_q - alu_y - quot;
          state_d = S_EXP;
        end
      end

      // Start the power with exponent phi - 1, first a squaring of one.
      S_EXP: begin
        exp_d    = phi_q - 1'b1;
        ecnt_d   = CNT_TOP;
        acc_d    = MB'(1);
        mx_d     = MB'(1);
        dq_d     = MB'(1);
        rem_d    = '0;
        cnt_d    = CNT_TOP;
        mphase_d = 1'b0;
        mop_d    = 1'b0;
        state_d  = S_MUL;
      end

      // Modular multiplication, multiplier bits from the top: double, then add.
      S_MUL: begin
        rem_d    = alu_y;
        mphase_d = !mphase_q;
        if (mphase_q) begin
          dq_d  = {dq_q[MB-2:0], 1'b0};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            acc_d    = alu_y;
            rem_d    = '0;
            cnt_d    = CNT_TOP;
            mphase_d = 1'b0;
            if (!mop_q && exp_q[MB-1]) begin
              mx_d  = base_q;
              dq_d  = alu_y;
              mop_d = 1'b1;
            end else begin
              exp_d  = {exp_q[MB-2:0], 1'b0};
              ecnt_d = ecnt_q - 1'b1;
              mx_d   = alu_y;
              dq_d   = alu_y;
              mop_d  = 1'b0;
              if (ecnt_q == '0) begin
                state_d = S_OUT;
              end
            end
          end
        end
      end

      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!ov_q || out_ch_o.ready) begin
          res_d   = acc_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    rest_q   <= rest_d;
    phi_q    <= phi_d;
    d_q      <= d_d;
    dsq_q    <= dsq_d;
    found_q  <= found_d;
    base_q   <= base_d;
    acc_q    <= acc_d;
    exp_q    <= exp_d;
    ecnt_q   <= ecnt_d;
    mx_q     <= mx_d;
    mphase_q <= mphase_d;
    mop_q    <= mop_d;
    res_q    <= res_d;
  end

endmodule

[bench/tb_modular_inverse_by_totient.sv]
`timescale 1ns / 1ps

module tb_modular_inverse_by_totient;

  localparam int unsigned MOD_BITS  = 31;
  localparam int unsigned REG_MODULUS = 0;
  localparam int unsigned WDOG_LIMIT = 200000;
  localparam logic [MOD_BITS-1:0] VALUE_MAX = '1;

  // Holds the inverses still owed by the block, oldest first.
  class inverse_board;
    logic [MOD_BITS-1:0] owed_q[$];

    function void note_value(logic [MOD_BITS-1:0] inv);
      owed_q = {owed_q, inv};
    endfunction

    // Returns 1 on a match; owed holds what was due (X when nothing was).
    function bit check_result(logic [MOD_BITS-1:0] got, output logic [MOD_BITS-1:0] owed,
                              output bit was_owed);
      was_owed = (owed_q.size() != 0);
      owed = 'x;
      if (!was_owed) return 0;
      owed = owed_q.pop_front();
      return (got == owed);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mit_in_if  #(.W(MOD_BITS)) in_if ();
  mit_out_if #(.W(MOD_BITS)) out_if ();

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  inverse_board board = new();
  int unsigned mismatches = 0;
  logic [MOD_BITS-1:0] cur_modulus = MOD_BITS'(2);
  int unsigned idle_cycles = 0;

  modular_inverse_by_totient #(.MOD_BITS(MOD_BITS)) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_if),
    .out_ch_o (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.value = '0;
    out_if.ready = 1'b0;
  end

  // a * b mod m with a, b < m < 2^31, so the product fits in 64 bits.
  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    return (a * b) % m;
  endfunction

  // Euler's totient by trial division.
  function automatic longint unsigned euler_phi(longint unsigned m);
    longint unsigned rest;
    longint unsigned phi;
    longint unsigned d;
    rest = m;
    phi = m;
    for (d = 2; d <= rest / d; d++) begin
      if (rest % d == 0) begin
        while (rest % d == 0) rest = rest / d;
        phi = phi / d * (d - 1);
      end
    end
    if (rest > 1) phi = phi / rest * (rest - 1);
    return phi;
  endfunction

  // value^(phi(m)-1) mod m, with a modulus below two taken as two.
  function automatic logic [MOD_BITS-1:0] euler_inverse(logic [MOD_BITS-1:0] modulus,
                                                        logic [MOD_BITS-1:0] value);
    longint unsigned m;
    longint unsigned b;
    longint unsigned e;
    longint unsigned acc;
    m = (modulus < 2) ? 2 : modulus;
    b = value % m;
    e = euler_phi(m) - 1;
    acc = 1 % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc[MOD_BITS-1:0];
  endfunction

  task automatic report(string what, logic [MOD_BITS-1:0] got, logic [MOD_BITS-1:0] owed);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, owed, $realtime);
    mismatches++;
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_modulus(logic [MOD_BITS-1:0] m);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_MODULUS);
    pwdata <= 32'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_modulus = m;
  endtask

  // Send one value after a random gap and note its inverse once accepted.
  task automatic send_value(logic [MOD_BITS-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_value(euler_inverse(cur_modulus, v));
  endtask

  // Lower valid and wait until every owed result is back, then let the block settle.
  task automatic drain();
    @(posedge clk_i);
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [MOD_BITS-1:0] smooth_modulus();
    int unsigned primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97};
    longint unsigned m;
    longint unsigned p;
    m = 1;
    repeat (40) begin
      p = primes[$urandom_range(0, 11)];
      if (m * p < (64'd1 << MOD_BITS)) m = m * p;
    end
    return (m < 2) ? MOD_BITS'(2) : m[MOD_BITS-1:0];
  endfunction

  function automatic logic [MOD_BITS-1:0] pick_value(logic [MOD_BITS-1:0] m);
    case ($urandom_range(0, 5))
      0: return MOD_BITS'($urandom() & VALUE_MAX);
      1: return MOD_BITS'($urandom() & VALUE_MAX);
      2: return VALUE_MAX;
      3: return (m < 2) ? MOD_BITS'(1) : m - MOD_BITS'(1);
      default: return (m < 2) ? '0 : MOD_BITS'($urandom_range(0, m - 1));
    endcase
  endfunction

  // Sink: random stall before each result, then check it.
  initial begin
    logic [MOD_BITS-1:0] owed;
    bit was_owed;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (!board.check_result(out_if.result, owed, was_owed))
        report(was_owed ? "result" : "unexpected result", out_if.result, owed);
    end
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [MOD_BITS-1:0] dir_mod[7] = '{2, 3, 0, 1, 31'h7FFF_FFFE, 97, 31'h4000_0000};
    logic [MOD_BITS-1:0] m;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset modulus, then register extremes with field extremes.
    send_value('0);
    send_value(VALUE_MAX);
    send_value(MOD_BITS'(1));
    drain();
    foreach (dir_mod[i]) begin
      write_modulus(dir_mod[i]);
      send_value('0);
      send_value(VALUE_MAX);
      send_value(dir_mod[i]);
      if (dir_mod[i] > 1) send_value(dir_mod[i] - MOD_BITS'(1));
      drain();
    end

    // Random phases: mostly moderate moduli, some large smooth ones.
    repeat (9) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: m = MOD_BITS'($urandom_range(2, 65535));
        5, 6, 7:       m = smooth_modulus();
        default:       m = MOD_BITS'($urandom_range(0, 64));
      endcase
      write_modulus(m);
      repeat ($urandom_range(5, 11)) send_value(pick_value(m));
      drain();
    end

    if (mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
